FILE: hw/rtl/mti_pkg.sv
// ----------------------------------------------------------------------------
// mti_pkg
// shared widths, register indexes, reset values and helper functions of the
// map triangle interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package mti_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 16;

  // lengths hold up to 256, indexes up to 255
  localparam int LEN_W  = 9;
  localparam int IDX_W  = 8;
  localparam int FRAC_W = 16;
  localparam int LIN_W  = 17;

  // quotient of v * 2^16 / spacing is below 2^24
  localparam int QUO_W     = 24;
  localparam int DIV_STEPS = 24;

  // shared multiplier and accumulator
  localparam int MA_W   = 35;
  localparam int MB_W   = 18;
  localparam int PROD_W = 53;
  localparam int ACC_W  = 54;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_SPACING_A = 2'd2;
  localparam logic [1:0] REG_SPACING_B = 2'd3;

  localparam logic [4:0]  COLUMNS_RESET = 5'd16;
  localparam logic [4:0]  ROWS_RESET    = 5'd16;
  localparam logic [31:0] SPACING_RESET = 32'h0001_0000;

  localparam logic [16:0] FRAC_ONE = 17'h1_0000;

  function automatic logic [LEN_W-1:0] eff_len(input logic [4:0] len_reg,
                                               input logic [LEN_W-1:0] max_v);
    if (len_reg == 5'd0) begin
      return LEN_W'(1);
    end else if (LEN_W'(len_reg) > max_v) begin
      return max_v;
    end else begin
      return LEN_W'(len_reg);
    end
  endfunction

  function automatic logic [31:0] nz_spacing(input logic [31:0] sp);
    return (sp == 32'd0) ? 32'd1 : sp;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/map_triangle_interpolator_core.sv
// ----------------------------------------------------------------------------
// map_triangle_interpolator_core
// 2d calibration map with triangular interpolation: write items store one
// entry, lookup items return the interpolated value at a q16.16 point
// ----------------------------------------------------------------------------
// lookup item: two 24-step divisions on one subtractor, four map reads and four
//   multiplier passes before out_valid, longer while a result is stalled; no new
//   item is accepted until the sequencer is back in idle
// write item: written to the map as it is accepted, no result
// reset: synchronous; control and config registers return to defaults, then a
//   clearing pass zeroes all MAX_COLUMNS*MAX_ROWS entries, one a cycle, no item taken
`default_nettype none

module map_triangle_interpolator_core
  import mti_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [3:0]         in_entry_column,
  input  wire logic [3:0]         in_entry_row,
  input  wire logic signed [31:0] in_entry_value,
  input  wire logic signed [31:0] in_query_first,
  input  wire logic signed [31:0] in_query_second,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_interpolated_value,

  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP    = 4'd1;
  localparam logic [3:0] S_CLAMP = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FRAC  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  // control
  logic [3:0]    state_r, state_nxt;
  logic          axis_r, axis_nxt;
  logic [4:0]    div_cnt_r, div_cnt_nxt;
  logic [2:0]    rd_cnt_r, rd_cnt_nxt;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          out_valid_r, out_valid_nxt;

  // configuration
  logic [4:0]  cols_r, rows_r;
  logic [31:0] spa_r, spb_r;
  logic        cfg_wr;

  // datapath
  logic signed [31:0]     qx_r, qy_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [31:0]            rem_r;
  logic [QUO_W-1:0]       dvd_r, quo_r;
  logic [IDX_W-1:0]       x_lo_r, x_hi_r, y_lo_r, y_hi_r;
  logic [FRAC_W-1:0]      fx_r, fy_r;
  logic signed [31:0]     corner_r [4];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]     out_value_r;

  // memory
  logic [31:0]   mem [DEPTH];
  logic [31:0]   mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [31:0]   mem_wdata;

  logic in_accept, look_start, out_load, wr_ok;
  logic [LIN_W-1:0] wr_lin, rd_lin;
  logic [IDX_W-1:0] rd_col, rd_row;

  // per-axis locate
  logic [LEN_W-1:0]  len_x, len_y, ax_len, lenm1;
  logic [31:0]       ax_sp;
  logic signed [31:0] ax_q;
  logic [39:0]       upper;
  logic [30:0]       v_cl;
  logic [32:0]       trial, sp33, diff33;
  logic              ge;
  logic [IDX_W-1:0]  i1, lo_sel, hi_sel;
  logic              hi_ok;
  logic [FRAC_W-1:0] frac_sel;

  // triangle and shared multiplier
  logic              le_diag, le_anti;
  logic signed [31:0] tri_p, tri_q, oth_1, oth_2;
  logic [FRAC_W-1:0] tri_u;
  logic [16:0]       tri_w;
  logic signed [32:0] diff_qp;
  logic signed [MA_W-1:0] kd, mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_full;
  logic [ACC_W-1:0]  acc_bias;

  // ---------------------------------------------------------------- handshake
  assign in_stall   = clr_busy_r || (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign look_start = in_accept && (in_command == CMD_LOOKUP);
  assign out_load   = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign out_valid              = out_valid_r;
  assign out_interpolated_value = out_value_r;

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_COLUMNS:   cfg_prdata = {27'd0, cols_r};
      REG_ROWS:      cfg_prdata = {27'd0, rows_r};
      REG_SPACING_A: cfg_prdata = spa_r;
      REG_SPACING_B: cfg_prdata = spb_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLUMNS_RESET;
      rows_r <= ROWS_RESET;
      spa_r  <= SPACING_RESET;
      spb_r  <= SPACING_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_COLUMNS:   cols_r <= cfg_pwdata[4:0];
        REG_ROWS:      rows_r <= cfg_pwdata[4:0];
        REG_SPACING_A: spa_r  <= cfg_pwdata;
        REG_SPACING_B: spb_r  <= cfg_pwdata;
      endcase
    end
  end

  // ---------------------------------------------------------------- map memory
  assign wr_ok  = (LEN_W'(in_entry_column) < LEN_W'(MAX_COLUMNS)) &&
                  (LEN_W'(in_entry_row) < LEN_W'(MAX_ROWS));
  assign wr_lin = LIN_W'(in_entry_column) * LIN_W'(MAX_ROWS) + LIN_W'(in_entry_row);

  assign rd_col  = rd_cnt_r[1] ? x_hi_r : x_lo_r;
  assign rd_row  = rd_cnt_r[0] ? y_hi_r : y_lo_r;
  assign rd_lin  = LIN_W'(rd_col) * LIN_W'(MAX_ROWS) + LIN_W'(rd_row);
  assign rd_addr = rd_lin[AW-1:0];

  assign mem_we    = clr_busy_r || (in_accept && (in_command == CMD_WRITE) && wr_ok);
  assign mem_waddr = clr_busy_r ? clr_addr_r : wr_lin[AW-1:0];
  assign mem_wdata = clr_busy_r ? 32'd0 : in_entry_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- locate
  assign len_x  = eff_len(cols_r, LEN_W'(MAX_COLUMNS));
  assign len_y  = eff_len(rows_r, LEN_W'(MAX_ROWS));
  assign ax_len = axis_r ? len_y : len_x;
  assign lenm1  = ax_len - LEN_W'(1);
  assign ax_sp  = nz_spacing(axis_r ? spb_r : spa_r);
  assign ax_q   = axis_r ? qy_r : qx_r;

  assign upper = prod_r[39:0];

  always_comb begin
    priority if (ax_q[31]) begin
      v_cl = '0;
    end else if (40'(ax_q[30:0]) > upper) begin
      v_cl = upper[30:0];
    end else begin
      v_cl = ax_q[30:0];
    end
  end

  assign trial  = {rem_r, dvd_r[QUO_W-1]};
  assign sp33   = {1'b0, ax_sp};
  assign ge     = (trial >= sp33);
  assign diff33 = trial - sp33;

  assign i1       = quo_r[QUO_W-1:FRAC_W];
  assign lo_sel   = (LEN_W'(i1) > lenm1) ? lenm1[IDX_W-1:0] : i1;
  assign hi_ok    = (LEN_W'(lo_sel) + LEN_W'(1)) < ax_len;
  assign hi_sel   = hi_ok ? (lo_sel + IDX_W'(1)) : lo_sel;
  assign frac_sel = hi_ok ? quo_r[FRAC_W-1:0] : '0;

  // ---------------------------------------------------------------- triangle
  // corners: 0 (lo,lo) 1 (lo,hi) 2 (hi,lo) 3 (hi,hi)
  assign le_diag = (fy_r <= fx_r);
  assign le_anti = ({1'b0, fx_r} + {1'b0, fy_r}) <= FRAC_ONE;

  always_comb begin
    unique case ({le_diag, le_anti})
      2'b11: begin
        tri_p = corner_r[0]; tri_q = corner_r[2];
        oth_1 = corner_r[1]; oth_2 = corner_r[3];
        tri_u = fx_r;        tri_w = {1'b0, fy_r};
      end
      2'b10: begin
        tri_p = corner_r[2]; tri_q = corner_r[3];
        oth_1 = corner_r[0]; oth_2 = corner_r[1];
        tri_u = fy_r;        tri_w = FRAC_ONE - {1'b0, fx_r};
      end
      2'b01: begin
        tri_p = corner_r[0]; tri_q = corner_r[1];
        oth_1 = corner_r[2]; oth_2 = corner_r[3];
        tri_u = fy_r;        tri_w = {1'b0, fx_r};
      end
      2'b00: begin
        tri_p = corner_r[1]; tri_q = corner_r[3];
        oth_1 = corner_r[0]; oth_2 = corner_r[2];
        tri_u = fx_r;        tri_w = FRAC_ONE - {1'b0, fy_r};
      end
    endcase
  end

  assign diff_qp = 33'(tri_q) - 33'(tri_p);
  assign kd      = MA_W'(oth_1) + MA_W'(oth_2) - MA_W'(tri_p) - MA_W'(tri_q);

  always_comb begin
    unique case (state_r)
      S_UP: begin
        mul_a = $signed({3'b000, ax_sp});
        mul_b = $signed({9'd0, lenm1});
      end
      S_MUL1: begin
        mul_a = MA_W'(diff_qp);
        mul_b = $signed({2'b00, tri_u});
      end
      S_MUL2: begin
        mul_a = kd;
        mul_b = $signed({1'b0, tri_w});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // truncation toward zero of acc / 2^18
  assign acc_bias = acc_r[ACC_W-1] ? (acc_r + ACC_W'(18'h3_FFFF)) : acc_r;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    div_cnt_nxt   = div_cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (look_start) begin
          state_nxt = S_UP;
          axis_nxt  = 1'b0;
        end
      end
      S_UP: state_nxt = S_CLAMP;
      S_CLAMP: begin
        state_nxt   = S_DIV;
        div_cnt_nxt = 5'(DIV_STEPS - 1);
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd0) begin
          state_nxt = S_FRAC;
        end
      end
      S_FRAC: begin
        if (!axis_r) begin
          state_nxt = S_UP;
          axis_nxt  = 1'b1;
        end else begin
          state_nxt  = S_RD;
          rd_cnt_nxt = 3'd0;
        end
      end
      S_RD: begin
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == 3'd4) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ACC;
      S_ACC:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      div_cnt_r   <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      div_cnt_r   <= div_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (look_start) begin
      qx_r <= in_query_first;
      qy_r <= in_query_second;
    end
    unique case (state_r)
      S_UP, S_MUL1: prod_r <= prod_full;
      S_CLAMP: begin
        rem_r <= 32'(v_cl[30:8]);
        dvd_r <= {v_cl[7:0], 16'd0};
        quo_r <= '0;
      end
      S_DIV: begin
        rem_r <= ge ? diff33[31:0] : trial[31:0];
        dvd_r <= {dvd_r[QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], ge};
      end
      S_FRAC: begin
        if (!axis_r) begin
          x_lo_r <= lo_sel;
          x_hi_r <= hi_sel;
          fx_r   <= frac_sel;
        end else begin
          y_lo_r <= lo_sel;
          y_hi_r <= hi_sel;
          fy_r   <= frac_sel;
        end
      end
      S_RD: begin
        if (rd_cnt_r != 3'd0) begin
          corner_r[rd_cnt_r[1:0] - 2'd1] <= mem_q_r;
        end
      end
      S_MUL2: begin
        prod_r <= prod_full;
        acc_r  <= (ACC_W'(tri_p) <<< 18) + (ACC_W'(prod_r) <<< 2);
      end
      S_ACC: acc_r <= acc_r + (ACC_W'(prod_r) <<< 1);
      S_FIN: begin
        if (out_load) begin
          out_value_r <= acc_bias[49:18];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- assertions
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!out_valid_r && (state_r == S_IDLE)))
    else $error("activity during map clearing pass");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < 5'(DIV_STEPS)))
    else $error("division step count out of range");

  a_edge_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((x_hi_r != x_lo_r) || (fx_r == '0)) &&
                          ((y_hi_r != y_lo_r) || (fy_r == '0)))
    else $error("nonzero fraction on clamped edge");

  a_hi_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((x_hi_r == x_lo_r) || (x_hi_r == x_lo_r + IDX_W'(1))) &&
                          ((y_hi_r == y_lo_r) || (y_hi_r == y_lo_r + IDX_W'(1))))
    else $error("upper index not next to lower index");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished lookup not delivered to output register");

endmodule

`default_nettype wire
